// ===== rtl/core/segint_pkg.sv =====
package segint_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // the four endpoints of one item
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } points_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // difference vectors, named target minus origin
  typedef struct packed {
    vec_t ba;
    vec_t dc;
    vec_t ac;
    vec_t bc;
    vec_t ad;
    vec_t bd;
    vec_t ca;
    vec_t da;
    vec_t cb;
    vec_t db;
  } diffs_t;

  // partial products: left and right term of each cross or dot product
  typedef struct packed {
    prod_t par_l;
    prod_t par_r;
    prod_t col_l;
    prod_t col_r;
    prod_t sa_l;
    prod_t sa_r;
    prod_t sb_l;
    prod_t sb_r;
    prod_t sc_l;
    prod_t sc_r;
    prod_t ia_l;
    prod_t ia_r;
    prod_t ib_l;
    prod_t ib_r;
    prod_t ic_l;
    prod_t ic_r;
    prod_t id_l;
    prod_t id_r;
  } prods_t;

  // sign flags of the finished cross and dot products
  typedef struct packed {
    logic par_zero;
    logic col_zero;
    logic sa_pos;
    logic sa_neg;
    logic sb_pos;
    logic sb_neg;
    logic sc_pos;
    logic sc_neg;
    logic sd_pos;
    logic sd_neg;
    logic in_a;
    logic in_b;
    logic in_c;
    logic in_d;
  } flags_t;

  // exact difference of two points
  function automatic vec_t vsub(coord_t px, coord_t py, coord_t qx, coord_t qy);
    vec_t r;
    r.x = DIFF_W'(px) - DIFF_W'(qx);
    r.y = DIFF_W'(py) - DIFF_W'(qy);
    return r;
  endfunction

  // exact product of two differences
  function automatic prod_t pmul(diff_t p, diff_t q);
    prod_t r;
    r = PROD_W'(p) * PROD_W'(q);
    return r;
  endfunction

endpackage

// ===== rtl/core/segint_diff.sv =====
module segint_diff (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  segint_pkg::points_t in_pts,
  output logic                out_valid,
  input  logic                out_ready,
  output segint_pkg::diffs_t  out_diffs
);
  import segint_pkg::*;

  diffs_t diffs_next;

  // stage can load when empty or when its item moves on
  assign in_ready = !out_valid || out_ready;

  // all difference vectors in parallel
  always_comb begin
    diffs_next.ba = vsub(in_pts.bx, in_pts.by, in_pts.ax, in_pts.ay);
    diffs_next.dc = vsub(in_pts.dx, in_pts.dy, in_pts.cx, in_pts.cy);
    diffs_next.ac = vsub(in_pts.ax, in_pts.ay, in_pts.cx, in_pts.cy);
    diffs_next.bc = vsub(in_pts.bx, in_pts.by, in_pts.cx, in_pts.cy);
    diffs_next.ad = vsub(in_pts.ax, in_pts.ay, in_pts.dx, in_pts.dy);
    diffs_next.bd = vsub(in_pts.bx, in_pts.by, in_pts.dx, in_pts.dy);
    diffs_next.ca = vsub(in_pts.cx, in_pts.cy, in_pts.ax, in_pts.ay);
    diffs_next.da = vsub(in_pts.dx, in_pts.dy, in_pts.ax, in_pts.ay);
    diffs_next.cb = vsub(in_pts.cx, in_pts.cy, in_pts.bx, in_pts.by);
    diffs_next.db = vsub(in_pts.dx, in_pts.dy, in_pts.bx, in_pts.by);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_diffs <= diffs_next;
    end
  end

endmodule

// ===== rtl/core/segint_mul.sv =====
module segint_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  segint_pkg::diffs_t in_diffs,
  output logic               out_valid,
  input  logic               out_ready,
  output segint_pkg::prods_t out_prods
);
  import segint_pkg::*;

  prods_t prods_next;

  assign in_ready = !out_valid || out_ready;

  // one multiplier per product term
  always_comb begin
    // direction cross (b-a) x (d-c)
    prods_next.par_l = pmul(in_diffs.ba.x, in_diffs.dc.y);
    prods_next.par_r = pmul(in_diffs.ba.y, in_diffs.dc.x);
    // (b-a) x (d-a), also the side of d about ab
    prods_next.col_l = pmul(in_diffs.ba.x, in_diffs.da.y);
    prods_next.col_r = pmul(in_diffs.ba.y, in_diffs.da.x);
    // side of a and b about cd
    prods_next.sa_l  = pmul(in_diffs.dc.x, in_diffs.ac.y);
    prods_next.sa_r  = pmul(in_diffs.dc.y, in_diffs.ac.x);
    prods_next.sb_l  = pmul(in_diffs.dc.x, in_diffs.bc.y);
    prods_next.sb_r  = pmul(in_diffs.dc.y, in_diffs.bc.x);
    // side of c about ab
    prods_next.sc_l  = pmul(in_diffs.ba.x, in_diffs.ca.y);
    prods_next.sc_r  = pmul(in_diffs.ba.y, in_diffs.ca.x);
    // dot products for the strictly-inside tests
    prods_next.ia_l  = pmul(in_diffs.ac.x, in_diffs.ad.x);
    prods_next.ia_r  = pmul(in_diffs.ac.y, in_diffs.ad.y);
    prods_next.ib_l  = pmul(in_diffs.bc.x, in_diffs.bd.x);
    prods_next.ib_r  = pmul(in_diffs.bc.y, in_diffs.bd.y);
    prods_next.ic_l  = pmul(in_diffs.ca.x, in_diffs.cb.x);
    prods_next.ic_r  = pmul(in_diffs.ca.y, in_diffs.cb.y);
    prods_next.id_l  = pmul(in_diffs.da.x, in_diffs.db.x);
    prods_next.id_r  = pmul(in_diffs.da.y, in_diffs.db.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_prods <= prods_next;
    end
  end

endmodule

// ===== rtl/core/segint_sign.sv =====
module segint_sign (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  segint_pkg::prods_t in_prods,
  output logic               out_valid,
  input  logic               out_ready,
  output segint_pkg::flags_t out_flags
);
  import segint_pkg::*;

  sum_t   par_sum;
  sum_t   col_sum;
  sum_t   sa_sum;
  sum_t   sb_sum;
  sum_t   sc_sum;
  sum_t   ia_sum;
  sum_t   ib_sum;
  sum_t   ic_sum;
  sum_t   id_sum;
  flags_t flags_next;

  assign in_ready = !out_valid || out_ready;

  // finish cross products (difference) and dot products (sum)
  always_comb begin
    par_sum = SUM_W'(in_prods.par_l) - SUM_W'(in_prods.par_r);
    col_sum = SUM_W'(in_prods.col_l) - SUM_W'(in_prods.col_r);
    sa_sum  = SUM_W'(in_prods.sa_l)  - SUM_W'(in_prods.sa_r);
    sb_sum  = SUM_W'(in_prods.sb_l)  - SUM_W'(in_prods.sb_r);
    sc_sum  = SUM_W'(in_prods.sc_l)  - SUM_W'(in_prods.sc_r);
    ia_sum  = SUM_W'(in_prods.ia_l)  + SUM_W'(in_prods.ia_r);
    ib_sum  = SUM_W'(in_prods.ib_l)  + SUM_W'(in_prods.ib_r);
    ic_sum  = SUM_W'(in_prods.ic_l)  + SUM_W'(in_prods.ic_r);
    id_sum  = SUM_W'(in_prods.id_l)  + SUM_W'(in_prods.id_r);
  end

  // reduce to sign flags
  always_comb begin
    flags_next.par_zero = (par_sum == '0);
    flags_next.col_zero = (col_sum == '0);
    flags_next.sa_neg   = sa_sum[SUM_W-1];
    flags_next.sa_pos   = !sa_sum[SUM_W-1] && (sa_sum != '0);
    flags_next.sb_neg   = sb_sum[SUM_W-1];
    flags_next.sb_pos   = !sb_sum[SUM_W-1] && (sb_sum != '0);
    flags_next.sc_neg   = sc_sum[SUM_W-1];
    flags_next.sc_pos   = !sc_sum[SUM_W-1] && (sc_sum != '0);
    flags_next.sd_neg   = col_sum[SUM_W-1];
    flags_next.sd_pos   = !col_sum[SUM_W-1] && (col_sum != '0);
    flags_next.in_a     = ia_sum[SUM_W-1];
    flags_next.in_b     = ib_sum[SUM_W-1];
    flags_next.in_c     = ic_sum[SUM_W-1];
    flags_next.in_d     = id_sum[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_flags <= flags_next;
    end
  end

endmodule

// ===== rtl/core/segment_intersection_test_core.sv =====
// Segment intersection test: each input item carries two segments AB and CD as signed
// 16-bit coordinates and yields one output item whose bit 0 is 1 when the segments cross
// properly (each segment's endpoints strictly on opposite sides of the other) or, when the
// directions are parallel, when they are collinear and some endpoint lies strictly inside
// the other segment. Touching at an endpoint does not count. Arithmetic is exact. The core
// takes one item every cycle unless backpressure holds it, through registered stages for the
// differences, eighteen 17x17 multipliers, a wide add with sign detect, and the output
// register holding the decision. Backpressure stalls each stage only as far as needed.
module segment_intersection_test_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, 16 bits each
  input  logic [segint_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // intersects, then zero fill
  output logic [segint_pkg::OUT_W-1:0] m_axis_tdata
);
  import segint_pkg::*;

  points_t pts;
  logic    d_valid;
  logic    d_ready;
  diffs_t  diffs;
  logic    p_valid;
  logic    p_ready;
  prods_t  prods;
  logic    f_valid;
  logic    f_ready;
  flags_t  flags;
  logic    intersects_next;
  logic    intersects;

  // unpack coordinates, first field lowest
  always_comb begin
    pts.ax = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    pts.ay = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    pts.bx = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    pts.by = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    pts.cx = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    pts.cy = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
    pts.dx = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
    pts.dy = s_axis_tdata[7*COORD_BITS +: COORD_BITS];
  end

  segint_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pts    (pts),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_diffs (diffs)
  );

  segint_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_diffs  (diffs),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_prods (prods)
  );

  segint_sign u_sign (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_prods  (prods),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_flags (flags)
  );

  // parallel case needs collinearity plus an interior endpoint, else proper crossing
  always_comb begin
    if (flags.par_zero) begin
      intersects_next = flags.col_zero &&
                        (flags.in_a || flags.in_b || flags.in_c || flags.in_d);
    end else begin
      intersects_next = ((flags.sa_pos && flags.sb_neg) || (flags.sa_neg && flags.sb_pos)) &&
                        ((flags.sc_pos && flags.sd_neg) || (flags.sc_neg && flags.sd_pos));
    end
  end

  // output register
  assign f_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (f_ready) begin
      m_axis_tvalid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && f_ready) begin
      intersects <= intersects_next;
    end
  end

  assign m_axis_tdata = {{(OUT_W-1){1'b0}}, intersects};

endmodule

// ===== rtl/core/segint_checker.sv =====
module segint_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [segint_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [segint_pkg::OUT_W-1:0] m_axis_tdata
);
  import segint_pkg::*;

  logic in_take;
  logic both_points;

  assign in_take = s_axis_tvalid && s_axis_tready;

  // both segments degenerate to single points: nothing lies strictly inside
  assign both_points =
    (s_axis_tdata[0*COORD_BITS +: COORD_BITS] == s_axis_tdata[2*COORD_BITS +: COORD_BITS]) &&
    (s_axis_tdata[1*COORD_BITS +: COORD_BITS] == s_axis_tdata[3*COORD_BITS +: COORD_BITS]) &&
    (s_axis_tdata[4*COORD_BITS +: COORD_BITS] == s_axis_tdata[6*COORD_BITS +: COORD_BITS]) &&
    (s_axis_tdata[5*COORD_BITS +: COORD_BITS] == s_axis_tdata[7*COORD_BITS +: COORD_BITS]);

  // stalled output item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // stalled output item keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // with the output side empty the pipeline can always take an item
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // fill bits of the output item are zero
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:1] == '0))
    else $error("output fill bits not zero");

  // point against point, no backpressure: a result reaches the output and it is zero
  a_point_pair: assert property (@(posedge clk) disable iff (rst)
    (in_take && both_points) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("point pair result wrong or late");

endmodule

bind segment_intersection_test_core segint_checker u_segint_checker (.*);
